/* rtl/lhr_pkg.sv */
// ----------------------------------------------------------------------------
// lhr_pkg
// Shared constants and codes for the line history ring.
// ----------------------------------------------------------------------------
`default_nettype none

package lhr_pkg;

  localparam int unsigned DepthDef   = 16;
  localparam int unsigned LineLenDef = 64;
  localparam int unsigned CharW      = 8;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_OLDER = 2'd1;
  localparam logic [1:0] ACT_NEWER = 2'd2;

  typedef enum logic [2:0] {
    KIND_CHAR   = 3'd0,
    KIND_NONE   = 3'd1,
    KIND_STORED = 3'd2,
    KIND_DUP    = 3'd3,
    KIND_EMPTY  = 3'd4
  } kind_e;

endpackage

`default_nettype wire

/* rtl/lhr_ram.sv */
// ----------------------------------------------------------------------------
// lhr_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module lhr_ram #(
  parameter int unsigned WIDTH   = 8,
  parameter int unsigned ENTRIES = 64,
  localparam int unsigned AW     = $clog2(ENTRIES)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [ENTRIES];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/line_history_ring.sv */
// ----------------------------------------------------------------------------
// line_history_ring
// Ring of DEPTH text lines with a browse cursor. A plain add character is
// staged, then compared with the newest entry. A line end runs compare, copy
// from the stage RAM to the line store one character a cycle, commit, result
// beat; an empty or duplicate line skips to the result beat. A browse streams
// one character beat per cycle unless the output stalls, from the single line
// store read port, up to LINE_LEN beats. Items are taken one at a time. Reset
// clears slot pointers, count and stage state; both RAMs stay unwritten.
// ----------------------------------------------------------------------------
`default_nettype none

module line_history_ring
  import lhr_pkg::*;
#(
  parameter int unsigned DEPTH    = DepthDef,
  parameter int unsigned LINE_LEN = LineLenDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       action_i,
  input  wire logic [CharW-1:0] char_in_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [2:0]       kind_o,
  output logic      [CharW-1:0] char_out_o,
  output logic                  last_o
);

  localparam int unsigned SlotW   = $clog2(DEPTH);
  localparam int unsigned CntW    = $clog2(DEPTH + 1);
  localparam int unsigned PosW    = $clog2(LINE_LEN);
  localparam int unsigned SumW    = SlotW + 1;
  localparam int unsigned StoreAw = SlotW + PosW;
  localparam int unsigned StoreN  = DEPTH * (2 ** PosW);

  localparam logic [SlotW-1:0] SlotLast = SlotW'(DEPTH - 1);
  localparam logic [CntW-1:0]  CntFull  = CntW'(DEPTH);
  localparam logic [SumW-1:0]  DepthS   = SumW'(DEPTH);
  localparam logic [PosW-1:0]  LenMax   = PosW'(LINE_LEN - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHAR   = 3'd1;
  localparam logic [2:0] S_END    = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;
  localparam logic [2:0] S_SOUT   = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [SlotW-1:0] head_q, head_d;
  logic [SlotW-1:0] browse_q, browse_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [PosW-1:0]  len_q, len_d;
  logic             too_long_q, too_long_d;
  logic             equal_q, equal_d;
  logic [CharW-1:0] ch_q, ch_d;
  kind_e            pend_q, pend_d;
  logic [PosW-1:0]  cp_q, cp_d;
  logic [PosW-1:0]  sp_q, sp_d;
  logic             wr_v_q, wr_v_d;
  logic [PosW-1:0]  wr_pos_q, wr_pos_d;
  logic             wr_term_q, wr_term_d;

  logic             out_valid_q, out_valid_d;
  kind_e            kind_q, kind_d;
  logic [CharW-1:0] char_q, char_d;
  logic             last_q, last_d;
  logic             out_load;

  logic               st_re, st_we;
  logic [StoreAw-1:0] st_raddr, st_waddr;
  logic [CharW-1:0]   st_wdata, st_rdata;
  logic               sg_re, sg_we;
  logic [PosW-1:0]    sg_raddr, sg_waddr;
  logic [CharW-1:0]   sg_wdata, sg_rdata;

  logic             in_acc, can_load;
  logic [SlotW-1:0] newest, head_nxt, browse_prv, browse_nxt, oldest;
  logic [SumW-1:0]  old_sum;
  logic [PosW-1:0]  sp_inc;

  lhr_ram #(
    .WIDTH  (CharW),
    .ENTRIES(StoreN)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  lhr_ram #(
    .WIDTH  (CharW),
    .ENTRIES(LINE_LEN)
  ) u_stage (
    .clk_i  (clk_i),
    .we_i   (sg_we),
    .waddr_i(sg_waddr),
    .wdata_i(sg_wdata),
    .re_i   (sg_re),
    .raddr_i(sg_raddr),
    .rdata_o(sg_rdata)
  );

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign can_load = !out_valid_q || !out_stall_i;

  assign newest     = (head_q == '0) ? SlotLast : head_q - 1'b1;
  assign head_nxt   = (head_q == SlotLast) ? '0 : head_q + 1'b1;
  assign browse_prv = (browse_q == '0) ? SlotLast : browse_q - 1'b1;
  assign browse_nxt = (browse_q == SlotLast) ? '0 : browse_q + 1'b1;
  assign old_sum    = SumW'(head_q) + DepthS - SumW'(count_q);
  assign oldest     = (old_sum >= DepthS) ? SlotW'(old_sum - DepthS) : SlotW'(old_sum);
  assign sp_inc     = sp_q + 1'b1;

  // Copy writes land in the cycle after the stage read; the terminator is forced.
  assign st_we    = wr_v_q;
  assign st_waddr = {head_q, wr_pos_q};
  assign st_wdata = wr_term_q ? '0 : sg_rdata;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    browse_d   = browse_q;
    count_d    = count_q;
    len_d      = len_q;
    too_long_d = too_long_q;
    equal_d    = equal_q;
    ch_d       = ch_q;
    pend_d     = pend_q;
    cp_d       = cp_q;
    sp_d       = sp_q;
    wr_v_d     = 1'b0;
    wr_pos_d   = wr_pos_q;
    wr_term_d  = wr_term_q;
    out_load   = 1'b0;
    kind_d     = kind_q;
    char_d     = char_q;
    last_d     = last_q;
    st_re      = 1'b0;
    st_raddr   = {newest, len_q};
    sg_re      = 1'b0;
    sg_raddr   = cp_q;
    sg_we      = 1'b0;
    sg_waddr   = len_q;
    sg_wdata   = char_in_i;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ch_d = char_in_i;
          case (action_i)
            ACT_ADD: begin
              if (char_in_i != '0) begin
                if (len_q < LenMax) begin
                  sg_we   = 1'b1;
                  st_re   = 1'b1;
                  state_d = S_CHAR;
                end else begin
                  too_long_d = 1'b1;
                  equal_d    = 1'b0;
                end
              end else if (len_q == '0) begin
                pend_d     = KIND_EMPTY;
                too_long_d = 1'b0;
                equal_d    = 1'b1;
                state_d    = S_EMIT;
              end else begin
                st_re   = 1'b1;
                state_d = S_END;
              end
            end
            ACT_OLDER: begin
              if (count_q == '0) begin
                pend_d  = KIND_NONE;
                state_d = S_EMIT;
              end else begin
                // Hold the cursor at the oldest entry.
                browse_d = (browse_q != oldest) ? browse_prv : browse_q;
                st_re    = 1'b1;
                st_raddr = {browse_d, {PosW{1'b0}}};
                sp_d     = '0;
                state_d  = S_SOUT;
              end
            end
            ACT_NEWER: begin
              if (count_q == '0) begin
                pend_d  = KIND_NONE;
                state_d = S_EMIT;
              end else if (browse_q == head_q) begin
                pend_d  = KIND_CHAR;
                state_d = S_EMIT;
              end else begin
                browse_d = browse_nxt;
                if (browse_nxt == head_q) begin
                  pend_d  = KIND_CHAR;
                  state_d = S_EMIT;
                end else begin
                  st_re    = 1'b1;
                  st_raddr = {browse_nxt, {PosW{1'b0}}};
                  sp_d     = '0;
                  state_d  = S_SOUT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_CHAR: begin
        if (!(equal_q && (count_q != '0) && (st_rdata == ch_q))) begin
          equal_d = 1'b0;
        end
        len_d   = len_q + 1'b1;
        state_d = S_IDLE;
      end

      S_END: begin
        if (equal_q && !too_long_q && (count_q != '0) && (st_rdata == '0)) begin
          pend_d     = KIND_DUP;
          len_d      = '0;
          too_long_d = 1'b0;
          equal_d    = 1'b1;
          state_d    = S_EMIT;
        end else begin
          cp_d    = '0;
          state_d = S_COPY;
        end
      end

      S_COPY: begin
        sg_re     = 1'b1;
        wr_v_d    = 1'b1;
        wr_pos_d  = cp_q;
        wr_term_d = (cp_q == len_q);
        if (cp_q == len_q) begin
          state_d = S_COMMIT;
        end else begin
          cp_d = cp_q + 1'b1;
        end
      end

      S_COMMIT: begin
        // Last copy write still uses the old head this cycle.
        head_d     = head_nxt;
        browse_d   = head_nxt;
        count_d    = (count_q == CntFull) ? count_q : count_q + 1'b1;
        pend_d     = KIND_STORED;
        len_d      = '0;
        too_long_d = 1'b0;
        equal_d    = 1'b1;
        state_d    = S_EMIT;
      end

      S_EMIT: begin
        if (can_load) begin
          out_load = 1'b1;
          kind_d   = pend_q;
          char_d   = '0;
          last_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      S_SOUT: begin
        if (can_load) begin
          out_load = 1'b1;
          kind_d   = KIND_CHAR;
          if ((sp_q == LenMax) || (st_rdata == '0)) begin
            char_d  = '0;
            last_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            // Advance the read while this beat goes out.
            char_d   = st_rdata;
            last_d   = 1'b0;
            sp_d     = sp_inc;
            st_re    = 1'b1;
            st_raddr = {browse_q, sp_inc};
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      browse_q    <= '0;
      count_q     <= '0;
      len_q       <= '0;
      too_long_q  <= 1'b0;
      equal_q     <= 1'b1;
      wr_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      browse_q    <= browse_d;
      count_q     <= count_d;
      len_q       <= len_d;
      too_long_q  <= too_long_d;
      equal_q     <= equal_d;
      wr_v_q      <= wr_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q      <= ch_d;
    pend_q    <= pend_d;
    cp_q      <= cp_d;
    sp_q      <= sp_d;
    wr_pos_q  <= wr_pos_d;
    wr_term_q <= wr_term_d;
    kind_q    <= kind_d;
    char_q    <= char_d;
    last_q    <= last_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign char_out_o  = char_q;
  assign last_o      = last_q;

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("entry count above ring depth");

  a_slot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q <= SlotLast) && (browse_q <= SlotLast))
    else $error("slot pointer outside ring");

  a_copy_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_v_q |-> ((state_q == S_COPY) || (state_q == S_COMMIT)))
    else $error("line store write outside copy");

  a_too_long_unequal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    too_long_q |-> !equal_q)
    else $error("over-long line still marked equal");

  a_commit_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |=> ((state_q == S_EMIT) && (pend_q == KIND_STORED)))
    else $error("commit not followed by stored result");

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for line_history_ring. A scripted run covers the
// empty ring, empty lines, duplicates, over-long lines and both browse ends.
// Random lines and browse bursts follow under four idle and stall mixes. A
// behavioral copy of the history ring predicts output beats, typed script rows
// naming their kind; each beat is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench
  import lhr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HistDepth = DepthDef;
  localparam int unsigned LineChars = LineLenDef;
  localparam logic [1:0]  ACT_NOP   = 2'd3;
  localparam int          RandItems = 170;
  localparam int          LongHold  = 400;
  localparam int          MaxPrints = 100;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
    logic       last;
  } hist_beat_t;

  typedef struct packed {
    logic [1:0] act;
    logic [7:0] ch;
    logic [7:0] reps;
    logic       typed;
    kind_e      kind;
  } script_row_t;

  localparam int ScriptRows = 29;
  localparam script_row_t SCRIPT [ScriptRows] = '{
    '{ACT_OLDER, 8'h00, 8'd1,  1'b1, KIND_NONE},   // nothing stored yet
    '{ACT_NEWER, 8'hFF, 8'd1,  1'b1, KIND_NONE},
    '{ACT_ADD,   8'h00, 8'd1,  1'b1, KIND_EMPTY},  // bare terminator
    '{ACT_NOP,   8'hA5, 8'd1,  1'b0, KIND_CHAR},   // unused action code
    '{ACT_ADD,   8'h68, 8'd1,  1'b0, KIND_CHAR},
    '{ACT_ADD,   8'hFF, 8'd1,  1'b0, KIND_CHAR},
    '{ACT_ADD,   8'h01, 8'd1,  1'b0, KIND_CHAR},
    '{ACT_ADD,   8'h00, 8'd1,  1'b1, KIND_STORED},
    '{ACT_ADD,   8'h68, 8'd1,  1'b0, KIND_CHAR},
    '{ACT_ADD,   8'hFF, 8'd1,  1'b0, KIND_CHAR},
    '{ACT_ADD,   8'h01, 8'd1,  1'b0, KIND_CHAR},
    '{ACT_ADD,   8'h00, 8'd1,  1'b1, KIND_DUP},
    '{ACT_ADD,   8'h68, 8'd1,  1'b0, KIND_CHAR},   // prefix of newest is new
    '{ACT_ADD,   8'h00, 8'd1,  1'b1, KIND_STORED},
    '{ACT_NEWER, 8'h00, 8'd1,  1'b1, KIND_CHAR},   // cursor already at head
    '{ACT_OLDER, 8'h00, 8'd1,  1'b0, KIND_CHAR},
    '{ACT_OLDER, 8'h00, 8'd1,  1'b0, KIND_CHAR},
    '{ACT_OLDER, 8'h00, 8'd1,  1'b0, KIND_CHAR},   // pinned at oldest
    '{ACT_NEWER, 8'h00, 8'd1,  1'b0, KIND_CHAR},
    '{ACT_NEWER, 8'h00, 8'd1,  1'b1, KIND_CHAR},   // steps onto head
    '{ACT_ADD,   8'h7E, 8'd63, 1'b0, KIND_CHAR},   // longest line kept whole
    '{ACT_ADD,   8'h00, 8'd1,  1'b1, KIND_STORED},
    '{ACT_ADD,   8'h7E, 8'd64, 1'b0, KIND_CHAR},   // one past: truncated
    '{ACT_ADD,   8'h00, 8'd1,  1'b1, KIND_STORED},
    '{ACT_ADD,   8'h7E, 8'd63, 1'b0, KIND_CHAR},
    '{ACT_ADD,   8'h00, 8'd1,  1'b1, KIND_DUP},
    '{ACT_OLDER, 8'h00, 8'd1,  1'b0, KIND_CHAR},
    '{ACT_ADD,   8'h00, 8'd1,  1'b1, KIND_EMPTY},
    '{ACT_NEWER, 8'h00, 8'd1,  1'b0, KIND_CHAR}
  };

  localparam int SendPct  [4] = '{0, 59, 0, 13};
  localparam int StallPct [4] = '{0, 0, 59, 13};

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [1:0] action_i    = ACT_ADD;
  logic [7:0] char_in_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [2:0] kind_o;
  logic [7:0] char_out_o;
  logic       last_o;

  // history ring mirror
  bit [7:0]    ring_text [HistDepth][LineChars];
  bit [7:0]    draft_buf [LineChars];
  int unsigned ring_head  = 0;
  int unsigned ring_fill  = 0;
  int unsigned view_slot  = 0;
  int unsigned draft_len  = 0;
  bit          draft_long = 1'b0;
  bit          draft_same = 1'b1;

  hist_beat_t fresh_beats [$];
  hist_beat_t pending_beats [$];

  int mismatches    = 0;
  int beats_seen    = 0;
  int items_done    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_asked    = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  line_history_ring uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .char_in_i   (char_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .char_out_o  (char_out_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic log_mismatch(string msg);
    if (mismatches < MaxPrints) $display("MISMATCH @%0t beat %0d: %s", $time, beats_seen, msg);
    mismatches++;
  endtask

  function automatic void stream_entry(int unsigned slot);
    for (int p = 0; p < LineChars - 1; p++) begin
      if (ring_text[slot][p] == 8'h00) break;
      fresh_beats.push_back('{KIND_CHAR, ring_text[slot][p], 1'b0});
    end
    fresh_beats.push_back('{KIND_CHAR, 8'h00, 1'b1});
  endfunction

  function automatic void predict_history(logic [1:0] act, logic [7:0] ch);
    int unsigned newest;
    int unsigned oldest;
    fresh_beats.delete();
    newest = (ring_head + HistDepth - 1) % HistDepth;
    case (act)
      ACT_ADD: begin
        if (ch != 8'h00) begin
          if (draft_len < LineChars - 1) begin
            if (draft_same && (ring_fill == 0 || ring_text[newest][draft_len] != ch))
              draft_same = 1'b0;
            draft_buf[draft_len] = ch;
            draft_len++;
          end else begin
            draft_long = 1'b1;
            draft_same = 1'b0;
          end
        end else begin
          if (draft_len == 0) begin
            fresh_beats.push_back('{KIND_EMPTY, 8'h00, 1'b1});
          end else if (draft_same && !draft_long && ring_fill > 0 &&
                       ring_text[newest][draft_len] == 8'h00) begin
            fresh_beats.push_back('{KIND_DUP, 8'h00, 1'b1});
          end else begin
            for (int i = 0; i < draft_len; i++) ring_text[ring_head][i] = draft_buf[i];
            ring_text[ring_head][draft_len] = 8'h00;
            ring_head = (ring_head + 1) % HistDepth;
            if (ring_fill < HistDepth) ring_fill++;
            view_slot = ring_head;
            fresh_beats.push_back('{KIND_STORED, 8'h00, 1'b1});
          end
          draft_len  = 0;
          draft_long = 1'b0;
          draft_same = 1'b1;
        end
      end
      ACT_OLDER: begin
        if (ring_fill == 0) begin
          fresh_beats.push_back('{KIND_NONE, 8'h00, 1'b1});
        end else begin
          oldest = (ring_head + HistDepth - ring_fill) % HistDepth;
          if (view_slot != oldest) view_slot = (view_slot + HistDepth - 1) % HistDepth;
          stream_entry(view_slot);
        end
      end
      ACT_NEWER: begin
        if (ring_fill == 0) begin
          fresh_beats.push_back('{KIND_NONE, 8'h00, 1'b1});
        end else if (view_slot == ring_head) begin
          fresh_beats.push_back('{KIND_CHAR, 8'h00, 1'b1});
        end else begin
          view_slot = (view_slot + 1) % HistDepth;
          if (view_slot == ring_head) fresh_beats.push_back('{KIND_CHAR, 8'h00, 1'b1});
          else stream_entry(view_slot);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] rand_char();
    case ($urandom_range(7))
      0: return 8'h01;
      1: return 8'hFF;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Present one beat, hold it until taken, then book its expected results.
  task automatic offer(logic [1:0] act, logic [7:0] ch, bit typed, kind_e kind);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    char_in_i  <= ch;
    do @(posedge clk_i); while (in_stall_o);
    predict_history(act, ch);
    if (typed) pending_beats.push_back('{kind, 8'h00, 1'b1});
    else foreach (fresh_beats[i]) pending_beats.push_back(fresh_beats[i]);
    if (act != ACT_NOP) items_done++;
  endtask

  always @(posedge clk_i) begin
    if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left   <= LongHold;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_beat
    hist_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_beats.size() == 0) begin
        log_mismatch($sformatf("unexpected beat kind %0d char %02h last %0b",
                               kind_o, char_out_o, last_o));
      end else begin
        want = pending_beats.pop_front();
        if (kind_o !== want.kind)
          log_mismatch($sformatf("kind %0d, want %0d", kind_o, want.kind));
        if (char_out_o !== want.ch)
          log_mismatch($sformatf("char %02h, want %02h", char_out_o, want.ch));
        if (last_o !== want.last)
          log_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
      end
      beats_seen++;
    end
  end

  initial begin
    script_row_t row;
    logic [7:0]  line_buf [$];
    logic [7:0]  prev_line [$];
    int          goal;
    int unsigned pick;
    int unsigned len;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < ScriptRows; r++) begin
      row = SCRIPT[r];
      for (int k = 0; k < row.reps; k++) offer(row.act, row.ch, row.typed, row.kind);
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = SendPct[ph];
      stall_pct    <= StallPct[ph];
      goal          = items_done + RandItems / 4;
      if (ph == 0) begin
        // hold the output off while browse beats keep coming, so the input backs up
        hold_asked <= hold_asked + 1;
        repeat (8) offer($urandom_range(1) ? ACT_OLDER : ACT_NEWER, rand_char(), 1'b0,
                         KIND_CHAR);
      end
      while (items_done < goal) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          line_buf.delete();
          pick = $urandom_range(99);
          if (pick < 8) begin
            // empty line
          end else if (pick < 20) begin
            line_buf = prev_line;
          end else if (pick < 26) begin
            line_buf = prev_line;
            if (line_buf.size() > 1 && $urandom_range(1)) void'(line_buf.pop_back());
            else line_buf.push_back(rand_char());
          end else begin
            len = (pick < 31) ? $urandom_range(60, 68) : $urandom_range(1, 4);
            repeat (len) line_buf.push_back(rand_char());
          end
          foreach (line_buf[i]) offer(ACT_ADD, line_buf[i], 1'b0, KIND_CHAR);
          offer(ACT_ADD, 8'h00, 1'b0, KIND_CHAR);
          prev_line = line_buf;
        end else if (pick < 94) begin
          repeat ($urandom_range(1, 4))
            offer($urandom_range(1) ? ACT_OLDER : ACT_NEWER, 8'($urandom), 1'b0, KIND_CHAR);
        end else if (pick < 97) begin
          offer(ACT_NOP, 8'($urandom), 1'b0, KIND_CHAR);
        end else begin
          // stray character: lands at the front of the next line
          offer(ACT_ADD, rand_char(), 1'b0, KIND_CHAR);
        end
      end
    end

    in_valid_i <= 1'b0;
    stall_pct  <= 0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (2 * LineChars) @(posedge clk_i);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
